>>> src/ederq_pkg.sv
// Shared types and constants for the duplicate-removing erase request queue.
// Used by ederq_scan and dedup_erase_request_queue; depends on nothing.
`default_nettype none

package ederq_pkg;

  localparam int BLOCK_W         = 5;
  localparam int BLOCK_COUNT_DEF = 28;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_BEGIN   = 2'd1,
    OP_FINISH  = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_QUEUED     = 2'd0,
    ST_RUNNING    = 2'd1,
    ST_SUCCESSFUL = 2'd2,
    ST_FAILED     = 2'd3
  } status_e;

  typedef struct packed {
    logic               valid;
    logic [BLOCK_W-1:0] block;
    status_e            status;
  } result_t;

endpackage

`default_nettype wire

>>> src/ederq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module ederq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/ederq_scan.sv
// Sequencer of the erase request queue: head, count and active mark, plus the
// one-entry-per-cycle search of the entry RAM. Depends on ederq_pkg.
`default_nettype none

module ederq_scan
  import ederq_pkg::*;
#(
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [1:0]                     opcode_i,
  input  wire logic [BLOCK_W-1:0]             block_i,
  input  wire logic                           success_i,
  output      logic                           busy_o,
  output      logic                           ram_we_o,
  output      logic [$clog2(BLOCK_COUNT)-1:0] ram_waddr_o,
  output      logic [BLOCK_W-1:0]             ram_wdata_o,
  output      logic [$clog2(BLOCK_COUNT)-1:0] ram_raddr_o,
  input  wire logic [BLOCK_W-1:0]             ram_rdata_i,
  output      result_t                        res_o
);

  localparam int IdxW = $clog2(BLOCK_COUNT);
  localparam int CntW = $clog2(BLOCK_COUNT + 1);
  localparam int SumW = CntW + 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_BEGIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [IdxW-1:0]    head_q, head_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               active_q, active_d;
  logic [CntW-1:0]    off_q, off_d;
  logic [IdxW-1:0]    slot_q, slot_d;
  logic [BLOCK_W-1:0] blk_q, blk_d;
  logic               succ_q, succ_d;

  logic [SumW-1:0]    tail_sum;
  logic [IdxW-1:0]    tail;
  logic [IdxW-1:0]    slot_next;
  logic [IdxW-1:0]    head_next;
  logic               in_range;
  logic               is_full;

  // Slot behind the last entry: head plus count stays below twice the depth.
  assign tail_sum  = SumW'(head_q) + SumW'(count_q);
  assign tail      = (tail_sum >= SumW'(BLOCK_COUNT))
                     ? IdxW'(tail_sum - SumW'(BLOCK_COUNT)) : IdxW'(tail_sum);
  assign slot_next = (slot_q == IdxW'(BLOCK_COUNT - 1)) ? '0 : slot_q + 1'b1;
  assign head_next = (head_q == IdxW'(BLOCK_COUNT - 1)) ? '0 : head_q + 1'b1;
  assign in_range  = ({1'b0, block_i} < (BLOCK_W + 1)'(BLOCK_COUNT));
  assign is_full   = (count_q == CntW'(BLOCK_COUNT));

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    active_d    = active_q;
    off_d       = off_q;
    slot_d      = slot_q;
    blk_d       = blk_q;
    succ_d      = succ_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = tail;
    ram_wdata_o = blk_q;
    ram_raddr_o = head_q;
    res_o       = '{valid: 1'b0, block: blk_q, status: ST_QUEUED};

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (op_e'(opcode_i))
            OP_REQUEST: begin
              blk_d = block_i;
              if (!in_range) begin
                res_o = '{valid: 1'b1, block: block_i, status: ST_FAILED};
              end else if (count_q == '0) begin
                // Nothing to search: append straight away.
                ram_we_o    = 1'b1;
                ram_wdata_o = block_i;
                count_d     = count_q + 1'b1;
                res_o       = '{valid: 1'b1, block: block_i, status: ST_QUEUED};
              end else begin
                slot_d  = head_q;
                off_d   = '0;
                state_d = S_SCAN;
              end
            end
            OP_BEGIN: begin
              if (count_q != '0 && !active_q) begin
                state_d = S_BEGIN;
              end
            end
            OP_FINISH: begin
              if (active_q && count_q != '0) begin
                succ_d  = success_i;
                state_d = S_FINISH;
              end
            end
            OP_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // Read data belongs to the entry at offset off_q from the head.
        if (ram_rdata_i == blk_q) begin
          res_o   = '{valid: 1'b1, block: blk_q,
                      status: (off_q == '0 && active_q) ? ST_RUNNING : ST_QUEUED};
          state_d = S_IDLE;
        end else if (off_q == count_q - 1'b1) begin
          if (is_full) begin
            res_o = '{valid: 1'b1, block: blk_q, status: ST_FAILED};
          end else begin
            ram_we_o = 1'b1;
            count_d  = count_q + 1'b1;
            res_o    = '{valid: 1'b1, block: blk_q, status: ST_QUEUED};
          end
          state_d = S_IDLE;
        end else begin
          off_d       = off_q + 1'b1;
          slot_d      = slot_next;
          ram_raddr_o = slot_next;
        end
      end

      S_BEGIN: begin
        res_o    = '{valid: 1'b1, block: ram_rdata_i, status: ST_RUNNING};
        active_d = 1'b1;
        state_d  = S_IDLE;
      end

      S_FINISH: begin
        res_o    = '{valid: 1'b1, block: ram_rdata_i,
                     status: succ_q ? ST_SUCCESSFUL : ST_FAILED};
        head_d   = head_next;
        count_d  = count_q - 1'b1;
        active_d = 1'b0;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      active_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q  <= off_d;
    slot_q <= slot_d;
    blk_q  <= blk_d;
    succ_q <= succ_d;
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

>>> src/dedup_erase_request_queue.sv
// Top level of the duplicate-removing erase request queue: entry RAM,
// sequencer and result register. Depends on ederq_pkg, ederq_ram, ederq_scan.
`default_nettype none

// An item is taken when start_i is high and busy_o is low. A request for a
// block out of range, or into an empty queue, finishes in the cycle it is
// taken; any other request reads one queued entry per cycle through the single
// read port of the entry RAM and holds busy_o until it finds a match or has
// read the last queued entry (there are at most BLOCK_COUNT). Begin and
// finish hold busy_o while the head entry is read. Begin on an empty or
// active queue, finish with nothing active, and opcode 3 give no result and
// finish at once. A result appears on block_out_o and status_o, marked by
// valid_o, for exactly one cycle, the cycle after the item completes; it is
// not held, so the receiver must take it then.
module dedup_erase_request_queue
  import ederq_pkg::*;
#(
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output      logic               busy_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [BLOCK_W-1:0] block_i,
  input  wire logic               success_i,
  output      logic               valid_o,
  output      logic [BLOCK_W-1:0] block_out_o,
  output      logic [1:0]         status_o
);

  localparam int IdxW = $clog2(BLOCK_COUNT);

  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  logic [BLOCK_W-1:0] ram_wdata;
  logic [IdxW-1:0]    ram_raddr;
  logic [BLOCK_W-1:0] ram_rdata;
  result_t            res;
  logic               scan_busy;

  logic               valid_q;
  logic [BLOCK_W-1:0] block_q;
  status_e            status_q;

  ederq_ram #(
    .WIDTH (BLOCK_W),
    .DEPTH (BLOCK_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ederq_scan #(
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .opcode_i    (opcode_i),
    .block_i     (block_i),
    .success_i   (success_i),
    .busy_o      (scan_busy),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    block_q  <= res.block;
    status_q <= res.status;
  end

  assign busy_o      = scan_busy;
  assign valid_o     = valid_q;
  assign block_out_o = block_q;
  assign status_o    = status_q;

  // An out-of-range request is refused in the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && opcode_i == OP_REQUEST
     && {1'b0, block_i} >= (BLOCK_W + 1)'(BLOCK_COUNT))
    |=> (valid_o && status_o == ST_FAILED && block_out_o == $past(block_i)))
    else $error("out-of-range request not refused");

  // The unused opcode never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && opcode_i == OP_NOP) |=> !valid_o)
    else $error("result after unused opcode");

  // A result only follows work: an accepted item or a busy cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(busy_o) || $past(start_i)))
    else $error("result without an item");

  // A successful finish result is always preceded by busy_o, while the head entry is read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == ST_SUCCESSFUL)) |-> $past(busy_o))
    else $error("finish result without head read");

endmodule

`default_nettype wire

>>> tb/erase_status_checker.sv
// Checker for the duplicate-removing erase request queue: predicts the status of every
// accepted item and compares it with the result strobes of the block.
// Depends on ederq_pkg.
module erase_status_checker
  import ederq_pkg::*;
#(
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cmd_start_i,
  input  wire logic               cmd_busy_i,
  input  wire logic [1:0]         cmd_opcode_i,
  input  wire logic [BLOCK_W-1:0] cmd_block_i,
  input  wire logic               cmd_success_i,
  input  wire logic               rsp_valid_i,
  input  wire logic [BLOCK_W-1:0] rsp_block_i,
  input  wire logic [1:0]         rsp_status_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  logic [BLOCK_W-1:0] queued_block [BLOCK_COUNT];
  int                 head_slot;
  int                 queued_count;
  logic               head_running;
  result_t            expected_status_q [$];

  // Applies one item to the shadow queue and returns the status it should report.
  function automatic result_t predict_erase_status(op_e op, logic [BLOCK_W-1:0] blk,
                                                   logic ok);
    result_t r;
    int      off;
    bit      found;
    r.valid  = 1'b0;
    r.block  = blk;
    r.status = ST_QUEUED;
    found    = 1'b0;
    case (op)
      OP_REQUEST: begin
        r.valid = 1'b1;
        if (blk >= BLOCK_COUNT) begin
          r.status = ST_FAILED;
        end else begin
          for (off = 0; off < queued_count && !found; off++) begin
            if (queued_block[(head_slot + off) % BLOCK_COUNT] == blk) begin
              found    = 1'b1;
              r.status = (off == 0 && head_running) ? ST_RUNNING : ST_QUEUED;
            end
          end
          if (!found) begin
            if (queued_count >= BLOCK_COUNT) begin
              r.status = ST_FAILED;
            end else begin
              queued_block[(head_slot + queued_count) % BLOCK_COUNT] = blk;
              queued_count++;
            end
          end
        end
      end
      OP_BEGIN: begin
        if (queued_count != 0 && !head_running) begin
          head_running = 1'b1;
          r.valid      = 1'b1;
          r.block      = queued_block[head_slot];
          r.status     = ST_RUNNING;
        end
      end
      OP_FINISH: begin
        if (head_running && queued_count != 0) begin
          r.valid      = 1'b1;
          r.block      = queued_block[head_slot];
          r.status     = ok ? ST_SUCCESSFUL : ST_FAILED;
          head_slot    = (head_slot + 1) % BLOCK_COUNT;
          queued_count--;
          head_running = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      head_slot    = 0;
      queued_count = 0;
      head_running = 1'b0;
      expected_status_q.delete();
    end else begin
      if (rsp_valid_i) begin
        if (expected_status_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got block %0d status %0d",
                   $time, rsp_block_i, rsp_status_i);
          fail_count_o++;
        end else begin
          want = expected_status_q.pop_front();
          if (rsp_block_i !== want.block) begin
            $display("%0t: block mismatch, expected %0d, got %0d",
                     $time, want.block, rsp_block_i);
            fail_count_o++;
          end
          if (rsp_status_i !== want.status) begin
            $display("%0t: status mismatch for block %0d, expected %0d, got %0d",
                     $time, want.block, want.status, rsp_status_i);
            fail_count_o++;
          end
        end
      end
      if (cmd_start_i && !cmd_busy_i) begin
        want = predict_erase_status(op_e'(cmd_opcode_i), cmd_block_i, cmd_success_i);
        if (want.valid) begin
          expected_status_q.push_back(want);
        end
      end
    end
    pending_o = expected_status_q.size();
  end

endmodule

>>> tb/tb_dedup_erase_request_queue.sv
// Testbench top for dedup_erase_request_queue: clock, reset, directed and random
// erase commands with sender gaps, watchdog and verdict.
// Depends on ederq_pkg, the block itself and erase_status_checker.
module tb_dedup_erase_request_queue;
  import ederq_pkg::*;

  localparam int BLOCK_COUNT    = BLOCK_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int PHASE_ITEMS    = 375;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  op_e                opcode = OP_NOP;
  logic [BLOCK_W-1:0] block = '0;
  logic               success = 1'b0;
  logic               busy_o;
  logic               valid_o;
  logic [BLOCK_W-1:0] block_out_o;
  logic [1:0]         status_o;
  int                 fail_count;
  int                 pending;
  int                 idle_pct = 0;
  int                 stalled_cycles = 0;
  logic [BLOCK_W-1:0] recent_blocks [4];

  always #6 clk_i = ~clk_i;

  dedup_erase_request_queue #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .opcode_i    (opcode),
    .block_i     (block),
    .success_i   (success),
    .valid_o     (valid_o),
    .block_out_o (block_out_o),
    .status_o    (status_o)
  );

  erase_status_checker #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_start_i   (start_i),
    .cmd_busy_i    (busy_o),
    .cmd_opcode_i  (opcode),
    .cmd_block_i   (block),
    .cmd_success_i (success),
    .rsp_valid_i   (valid_o),
    .rsp_block_i   (block_out_o),
    .rsp_status_i  (status_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Presents one item, possibly after a random gap, and returns once it is taken.
  task automatic issue_cmd(op_e op, logic [BLOCK_W-1:0] blk, logic ok);
    int gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      start_i <= 1'b0;
      opcode  <= op_e'($urandom_range(3));
      block   <= BLOCK_W'($urandom);
      success <= 1'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    opcode  <= op;
    block   <= blk;
    success <= ok;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Mostly valid blocks, often one that was asked for lately, now and then out of range.
  function automatic logic [BLOCK_W-1:0] pick_block();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return recent_blocks[2'($urandom_range(3))];
    if (roll < 88) return BLOCK_W'($urandom_range(BLOCK_COUNT - 1));
    return BLOCK_W'($urandom_range((1 << BLOCK_W) - 1));
  endfunction

  initial begin
    int          item_count;
    int          roll;
    bit          filling;
    op_e         op;
    logic [BLOCK_W-1:0] blk;
    int          phase_idle [4];
    phase_idle = '{0, 61, 0, 15};
    foreach (recent_blocks[k]) recent_blocks[k] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty queue, range limits, duplicates with and without an
    // active head, begin and finish in every state, both outcomes.
    issue_cmd(OP_REQUEST, 5'd0, 1'b0);
    issue_cmd(OP_REQUEST, BLOCK_W'(BLOCK_COUNT - 1), 1'b1);
    issue_cmd(OP_REQUEST, BLOCK_W'(BLOCK_COUNT), 1'b0);
    issue_cmd(OP_REQUEST, 5'd31, 1'b1);
    issue_cmd(OP_REQUEST, 5'd0, 1'b0);
    issue_cmd(OP_BEGIN, 5'd31, 1'b1);
    issue_cmd(OP_BEGIN, 5'd0, 1'b0);
    issue_cmd(OP_REQUEST, 5'd0, 1'b1);
    issue_cmd(OP_REQUEST, BLOCK_W'(BLOCK_COUNT - 1), 1'b0);
    issue_cmd(OP_FINISH, 5'd0, 1'b1);
    issue_cmd(OP_FINISH, 5'd31, 1'b1);
    issue_cmd(OP_NOP, 5'd31, 1'b1);
    issue_cmd(OP_BEGIN, 5'd0, 1'b0);
    issue_cmd(OP_FINISH, 5'd31, 1'b0);
    issue_cmd(OP_BEGIN, 5'd0, 1'b1);
    issue_cmd(OP_FINISH, 5'd0, 1'b1);
    issue_cmd(OP_REQUEST, 5'd5, 1'b0);
    issue_cmd(OP_BEGIN, 5'd0, 1'b0);
    issue_cmd(OP_REQUEST, 5'd5, 1'b1);
    issue_cmd(OP_FINISH, 5'd0, 1'b1);

    // Random part: alternate between filling the queue, which drives it to full
    // and through the wrap of the ring, and draining it with begin/finish pairs.
    foreach (phase_idle[p]) begin
      idle_pct   = phase_idle[p];
      item_count = 0;
      filling    = 1'b1;
      while (item_count < PHASE_ITEMS) begin
        if ($urandom_range(29) == 0) filling = ~filling;
        roll = $urandom_range(99);
        if (roll < 3) op = OP_NOP;
        else if (filling) op = (roll < 78) ? OP_REQUEST : (roll < 90) ? OP_BEGIN : OP_FINISH;
        else op = (roll < 28) ? OP_REQUEST : (roll < 63) ? OP_BEGIN : OP_FINISH;
        blk = pick_block();
        if (op == OP_REQUEST && blk < BLOCK_COUNT) begin
          recent_blocks[2'($urandom_range(3))] = blk;
        end
        issue_cmd(op, blk, 1'($urandom_range(1)));
        if (op != OP_NOP) item_count++;
      end
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (BLOCK_COUNT + 10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Ends the run if neither items nor results move for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || valid_o) begin
        stalled_cycles <= 0;
      end else begin
        stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
